// ===== src/dof_pkg.sv =====
// -----------------------------------------------------------------------------
// dof_pkg - shared types and constants for the dhcp options finder
// option codes, walker phases, result status codes and beat field widths
// -----------------------------------------------------------------------------
package dof_pkg;

    // default cap on the area length
    localparam int MAX_AREA_DEF = 1024;

    // field widths
    localparam int DATA_W   = 8;
    localparam int ALEN_W   = 11;
    localparam int STATUS_W = 3;
    localparam int VOFF_W   = 10;
    localparam int VLEN_W   = 8;

    // packed beat widths, rounded up to whole bytes
    localparam int S_TDATA_W = ((DATA_W + ALEN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VOFF_W + VLEN_W + 7) / 8) * 8;

    // special option codes
    localparam logic [DATA_W-1:0] OPT_PAD = 8'd0;
    localparam logic [DATA_W-1:0] OPT_END = 8'd255;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_END       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOLEN     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERRUN   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

    // walker phase, one-hot
    typedef enum logic [2:0] {
        PH_TYPE = 3'b001,
        PH_LEN  = 3'b010,
        PH_SKIP = 3'b100
    } phase_t;

endpackage

// ===== src/dhcp_option_finder.sv =====
// -----------------------------------------------------------------------------
// dhcp_option_finder - streaming search of a dhcp options area
// walks type-length-value options one byte per beat and reports the first
// option whose type matches the configured code, or why the search ended
// -----------------------------------------------------------------------------
//
//  channel   dir   handshake             payload
//  -------   ---   -------------------   ---------------------------------------
//  s_        in    s_tvalid / s_tready   tdata: data_byte, area_length
//                                        tuser: first_byte
//  m_        out   m_tvalid / m_tready   tdata: value_offset, value_length
//                                        tuser: status
//  cfg_      in    cfg_wr_en             cfg_wr_data: wanted_code
//
//  one beat per cycle sustained while no result beat is stalled; an input beat
//  passes the input register, then the result register
//  the walker state is updated by one compare-and-count step between the
//  input register and the result register
//  aresetn is synchronous, active low; it clears the walker as if a new area
//  had just started and sets the wanted code to zero
//  a stalled result beat holds the pipe; the input register still takes a
//  beat while it is empty, so both registers fill before s_tready drops
//
module dhcp_option_finder #(
    parameter int MAX_AREA = dof_pkg::MAX_AREA_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // configuration
    input  logic                          cfg_wr_en,
    input  logic [dof_pkg::DATA_W-1:0]    cfg_wr_data,   // wanted_code

    // options bytes in
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dof_pkg::S_TDATA_W-1:0] s_tdata,       // [7:0] data_byte,
                                                         // [18:8] area_length
    input  logic                          s_tuser,       // [0] first_byte

    // search result out
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dof_pkg::M_TDATA_W-1:0] m_tdata,       // [9:0] value_offset,
                                                         // [17:10] value_length
    output logic [dof_pkg::STATUS_W-1:0]  m_tuser        // [2:0] status
);

    // an area never exceeds what the length field can carry
    localparam int ALEN_MAX = (1 << dof_pkg::ALEN_W) - 1;
    localparam int LEN_CAP  = (MAX_AREA < ALEN_MAX) ? MAX_AREA : ALEN_MAX;
    // byte position runs 0..LEN_CAP
    localparam int POS_W    = $clog2(LEN_CAP + 1);
    // room for position + 1 + length byte, and for the area length
    localparam int SUM_W    = ((POS_W > dof_pkg::DATA_W) ? POS_W : dof_pkg::DATA_W) + 2;

    // configuration register
    logic [dof_pkg::DATA_W-1:0] wanted_reg;

    // input register
    logic                        s1_vld_reg;
    logic [dof_pkg::DATA_W-1:0]  s1_byte_reg;
    logic                        s1_first_reg;
    logic [dof_pkg::ALEN_W-1:0]  s1_alen_reg;

    // walker state
    logic [POS_W-1:0]            pos_reg,   pos_next;
    dof_pkg::phase_t             phase_reg, phase_next;
    logic [dof_pkg::DATA_W-1:0]  held_reg,  held_next;
    logic [dof_pkg::DATA_W-1:0]  skip_reg,  skip_next;
    logic                        done_reg,  done_next;

    // result register
    logic                         m_vld_reg;
    logic [dof_pkg::STATUS_W-1:0] m_status_reg;
    logic [dof_pkg::VOFF_W-1:0]   m_voff_reg;
    logic [dof_pkg::VLEN_W-1:0]   m_vlen_reg;

    // step results
    logic                         res_vld;
    logic [dof_pkg::STATUS_W-1:0] res_status;
    logic [dof_pkg::VOFF_W-1:0]   res_voff;
    logic [dof_pkg::VLEN_W-1:0]   res_vlen;

    logic [SUM_W-1:0] len_eff;
    logic [SUM_W-1:0] p_ext;
    logic [SUM_W-1:0] p_inc;
    logic [SUM_W-1:0] val_end;
    logic             adv;

    // the result register can take a new beat
    assign adv      = !m_vld_reg || m_tready;
    assign s_tready = !s1_vld_reg || adv;

    assign m_tvalid = m_vld_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = dof_pkg::M_TDATA_W'({m_vlen_reg, m_voff_reg});

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_reg <= '0;
        end else if (cfg_wr_en) begin
            wanted_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (s_tready) begin
            s1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            s1_byte_reg  <= s_tdata[dof_pkg::DATA_W-1:0];
            s1_alen_reg  <= s_tdata[dof_pkg::DATA_W +: dof_pkg::ALEN_W];
            s1_first_reg <= s_tuser;
        end
    end

    // one walker step on the registered byte
    always_comb begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        skip_next  = skip_reg;
        done_next  = done_reg;
        res_vld    = 1'b0;
        res_status = dof_pkg::ST_EXHAUSTED;
        res_voff   = '0;
        res_vlen   = '0;

        // effective area length, capped
        if (32'(s1_alen_reg) > MAX_AREA) begin
            len_eff = SUM_W'(MAX_AREA);
        end else begin
            len_eff = SUM_W'(s1_alen_reg);
        end

        // a first byte restarts the walker
        if (s1_first_reg) begin
            pos_next   = '0;
            phase_next = dof_pkg::PH_TYPE;
            held_next  = '0;
            skip_next  = '0;
            done_next  = 1'b0;
        end

        p_ext   = SUM_W'(pos_next);
        p_inc   = p_ext + SUM_W'(1);
        val_end = p_inc + SUM_W'(s1_byte_reg);

        if (!done_next) begin
            if (p_ext >= len_eff) begin
                // byte beyond the area
                res_vld    = 1'b1;
                res_status = dof_pkg::ST_EXHAUSTED;
            end else begin
                pos_next = POS_W'(p_inc);
                case (phase_next)
                    dof_pkg::PH_LEN: begin
                        if (val_end > len_eff) begin
                            res_vld    = 1'b1;
                            res_status = dof_pkg::ST_OVERRUN;
                        end else if (held_next == wanted_reg) begin
                            res_vld    = 1'b1;
                            res_status = dof_pkg::ST_FOUND;
                            res_voff   = p_inc[dof_pkg::VOFF_W-1:0];
                            res_vlen   = s1_byte_reg;
                        end else if (s1_byte_reg == '0) begin
                            phase_next = dof_pkg::PH_TYPE;
                        end else begin
                            phase_next = dof_pkg::PH_SKIP;
                            skip_next  = s1_byte_reg;
                        end
                    end
                    dof_pkg::PH_SKIP: begin
                        if (skip_next != '0) begin
                            skip_next = skip_next - 8'd1;
                        end
                        if (skip_next == '0) begin
                            phase_next = dof_pkg::PH_TYPE;
                        end
                    end
                    default: begin
                        // expect a type byte
                        phase_next = dof_pkg::PH_TYPE;
                        if (s1_byte_reg == dof_pkg::OPT_END) begin
                            res_vld    = 1'b1;
                            res_status = dof_pkg::ST_END;
                        end else if (s1_byte_reg != dof_pkg::OPT_PAD) begin
                            if (p_inc >= len_eff) begin
                                res_vld    = 1'b1;
                                res_status = dof_pkg::ST_NOLEN;
                            end else begin
                                held_next  = s1_byte_reg;
                                phase_next = dof_pkg::PH_LEN;
                            end
                        end
                    end
                endcase

                // area used up on an option boundary
                if (!res_vld && phase_next == dof_pkg::PH_TYPE && p_inc >= len_eff) begin
                    res_vld    = 1'b1;
                    res_status = dof_pkg::ST_EXHAUSTED;
                end
            end
            if (res_vld) begin
                done_next = 1'b1;
            end
        end
    end

    // walker state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            phase_reg <= dof_pkg::PH_TYPE;
            held_reg  <= '0;
            skip_reg  <= '0;
            done_reg  <= 1'b0;
            m_vld_reg <= 1'b0;
        end else if (adv) begin
            m_vld_reg <= s1_vld_reg && res_vld;
            if (s1_vld_reg) begin
                pos_reg   <= pos_next;
                phase_reg <= phase_next;
                held_reg  <= held_next;
                skip_reg  <= skip_next;
                done_reg  <= done_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s1_vld_reg && res_vld) begin
            m_status_reg <= res_status;
            m_voff_reg   <= res_voff;
            m_vlen_reg   <= res_vlen;
        end
    end

    // checks

    // walker phase stays one-hot
    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg))
        else $error("walker phase not one-hot");

    // only a found result carries an offset and a length
    a_zero_unless_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_vld_reg && m_status_reg != dof_pkg::ST_FOUND)
            |-> (m_voff_reg == '0 && m_vlen_reg == '0))
        else $error("non-found result carries value fields");

    // a concluded step closes the search
    a_done_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && s1_vld_reg && res_vld) |=> (done_reg && m_vld_reg))
        else $error("search not closed after a result");

    // no result while the search is closed and no restart comes
    a_no_result_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_vld_reg && done_reg && !s1_first_reg) |-> !res_vld)
        else $error("result from a closed search");

    // input back-pressure only with a full input register and stalled output
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_vld_reg && m_vld_reg && !m_tready))
        else $error("input stalled without cause");

endmodule
